@@ src/hcpd_pkg.sv @@
`default_nettype none

package hcpd_pkg;

  // field and state widths
  localparam int DUTY_BITS   = 10;
  localparam int ACC_BITS    = 16;
  localparam int CNT_BITS    = 20;
  localparam int CHAR_BITS   = 8;
  localparam int DIGIT_BITS  = 4;
  localparam int FLASH_SHIFT = 12;
  localparam int GAUGE_LSB   = 10;

  // stream word layout
  localparam int S_DATA_BITS = 16;
  localparam int M_DATA_BITS = 48;

  // duty constants
  localparam logic [DUTY_BITS-1:0] DUTY_MAX    = 10'h3FF;
  localparam logic [DUTY_BITS-1:0] DUTY_ZERO   = 10'h000;
  localparam logic [DUTY_BITS-1:0] COLOR_RESET = 10'h200;
  localparam logic [DUTY_BITS-1:0] GAUGE_RESET = 10'h0FF;
  localparam logic [DUTY_BITS-1:0] BLUE_BASE   = 10'h300;
  localparam logic [DUTY_BITS-1:0] GREEN_BASE  = 10'h200;
  localparam logic [DUTY_BITS-1:0] RED_BASE    = 10'h100;

  // demo counter reload, 0x280 shifted up by ten bits
  localparam logic [CNT_BITS-1:0] DEMO_RELOAD = 20'hA0000;

  // operation codes carried on tuser
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_BITS-1:0] CH_AT    = 8'h40;
  localparam logic [CHAR_BITS-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_BITS-1:0] CH_UP_B  = 8'h42;
  localparam logic [CHAR_BITS-1:0] CH_UP_G  = 8'h47;
  localparam logic [CHAR_BITS-1:0] CH_UP_R  = 8'h52;
  localparam logic [DIGIT_BITS-1:0] HEX_LETTER_OFS = 4'd9;

  typedef enum logic [3:0] {
    CMD_DIGIT,
    CMD_IGNORE,
    CMD_BLUE,
    CMD_GREEN,
    CMD_RED,
    CMD_GAUGE,
    CMD_ALL_OFF,
    CMD_ALL_ON,
    CMD_ERROR
  } cmd_t;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_ERR  = 2'd2
  } reply_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [DIGIT_BITS-1:0] digit;
  } char_info_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] blue;
    logic [DUTY_BITS-1:0] green;
    logic [DUTY_BITS-1:0] red;
    logic [DUTY_BITS-1:0] gauge;
    reply_t               reply;
  } result_t;

endpackage

`default_nettype wire

@@ src/hcpd_char_decode.sv @@
`default_nettype none

module hcpd_char_decode (
  input  wire logic [hcpd_pkg::CHAR_BITS-1:0] char_code,
  output hcpd_pkg::char_info_t                info
);

  // classify the character and extract a hex digit value
  always_comb begin
    info.digit = char_code[hcpd_pkg::DIGIT_BITS-1:0];
    unique case (char_code) inside
      [hcpd_pkg::CH_0:hcpd_pkg::CH_9]: begin
        info.cmd = hcpd_pkg::CMD_DIGIT;
      end
      [hcpd_pkg::CH_LO_A:hcpd_pkg::CH_LO_F]: begin
        info.cmd   = hcpd_pkg::CMD_DIGIT;
        info.digit = char_code[hcpd_pkg::DIGIT_BITS-1:0] + hcpd_pkg::HEX_LETTER_OFS;
      end
      hcpd_pkg::CH_LF:   info.cmd = hcpd_pkg::CMD_IGNORE;
      hcpd_pkg::CH_UP_B: info.cmd = hcpd_pkg::CMD_BLUE;
      hcpd_pkg::CH_UP_G: info.cmd = hcpd_pkg::CMD_GREEN;
      hcpd_pkg::CH_UP_R: info.cmd = hcpd_pkg::CMD_RED;
      hcpd_pkg::CH_CR:   info.cmd = hcpd_pkg::CMD_GAUGE;
      hcpd_pkg::CH_BANG: info.cmd = hcpd_pkg::CMD_ALL_OFF;
      hcpd_pkg::CH_AT:   info.cmd = hcpd_pkg::CMD_ALL_ON;
      default:           info.cmd = hcpd_pkg::CMD_ERROR;
    endcase
  end

endmodule

`default_nettype wire

@@ src/hcpd_engine.sv @@
`default_nettype none

module hcpd_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 operation,
  input  wire logic                 demo_switch,
  input  wire hcpd_pkg::char_info_t info,
  output hcpd_pkg::result_t         res_next
);

  logic [hcpd_pkg::ACC_BITS-1:0]  acc, acc_next;
  logic [hcpd_pkg::DUTY_BITS-1:0] blue, blue_next;
  logic [hcpd_pkg::DUTY_BITS-1:0] green, green_next;
  logic [hcpd_pkg::DUTY_BITS-1:0] red, red_next;
  logic [hcpd_pkg::DUTY_BITS-1:0] gauge, gauge_next;
  logic [hcpd_pkg::CNT_BITS-1:0]  cnt, cnt_next;
  hcpd_pkg::reply_t               reply;
  logic [hcpd_pkg::DUTY_BITS-1:0] acc_sat;
  logic [2:0]                     flash_sel;

  // accumulator clamped to full-scale duty
  assign acc_sat = (|acc[hcpd_pkg::ACC_BITS-1:hcpd_pkg::DUTY_BITS]) ?
                   hcpd_pkg::DUTY_MAX : acc[hcpd_pkg::DUTY_BITS-1:0];
  assign flash_sel = cnt[hcpd_pkg::FLASH_SHIFT +: 3];

  // next state for one word
  always_comb begin
    acc_next   = acc;
    blue_next  = blue;
    green_next = green;
    red_next   = red;
    gauge_next = gauge;
    cnt_next   = cnt;
    reply      = hcpd_pkg::REPLY_NONE;
    if (step && demo_switch && operation == hcpd_pkg::OP_CHAR) begin
      if (info.cmd != hcpd_pkg::CMD_DIGIT && info.cmd != hcpd_pkg::CMD_IGNORE) begin
        acc_next = '0;
      end
      unique case (info.cmd)
        hcpd_pkg::CMD_DIGIT: begin
          acc_next = {acc[hcpd_pkg::ACC_BITS-hcpd_pkg::DIGIT_BITS-1:0], info.digit};
        end
        hcpd_pkg::CMD_IGNORE: ;
        hcpd_pkg::CMD_BLUE:  blue_next  = ~acc_sat;
        hcpd_pkg::CMD_GREEN: green_next = ~acc_sat;
        hcpd_pkg::CMD_RED:   red_next   = ~acc_sat;
        hcpd_pkg::CMD_GAUGE: begin
          gauge_next = acc_sat;
          reply      = hcpd_pkg::REPLY_ACK;
        end
        hcpd_pkg::CMD_ALL_OFF: begin
          blue_next  = hcpd_pkg::DUTY_ZERO;
          green_next = hcpd_pkg::DUTY_ZERO;
          red_next   = hcpd_pkg::DUTY_ZERO;
          gauge_next = hcpd_pkg::DUTY_ZERO;
        end
        hcpd_pkg::CMD_ALL_ON: begin
          blue_next  = hcpd_pkg::DUTY_MAX;
          green_next = hcpd_pkg::DUTY_MAX;
          red_next   = hcpd_pkg::DUTY_MAX;
          gauge_next = hcpd_pkg::DUTY_MAX;
        end
        default: reply = hcpd_pkg::REPLY_ERR;
      endcase
    end else if (step && !demo_switch && operation == hcpd_pkg::OP_TICK) begin
      // color flash while the flash bit is clear
      if (!flash_sel[0]) begin
        blue_next  = flash_sel[2] ? hcpd_pkg::DUTY_MAX : hcpd_pkg::BLUE_BASE;
        green_next = flash_sel[1] ? hcpd_pkg::DUTY_MAX : hcpd_pkg::GREEN_BASE;
        red_next   = flash_sel[0] ? hcpd_pkg::DUTY_MAX : hcpd_pkg::RED_BASE;
      end
      // down counter with reload, gauge follows its upper bits
      if (cnt == '0) begin
        cnt_next = hcpd_pkg::DEMO_RELOAD;
      end else begin
        cnt_next = cnt - 1'b1;
      end
      gauge_next = cnt_next[hcpd_pkg::GAUGE_LSB +: hcpd_pkg::DUTY_BITS];
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      blue  <= hcpd_pkg::COLOR_RESET;
      green <= hcpd_pkg::COLOR_RESET;
      red   <= hcpd_pkg::COLOR_RESET;
      gauge <= hcpd_pkg::GAUGE_RESET;
      cnt   <= '0;
    end else begin
      acc   <= acc_next;
      blue  <= blue_next;
      green <= green_next;
      red   <= red_next;
      gauge <= gauge_next;
      cnt   <= cnt_next;
    end
  end

  assign res_next.blue  = blue_next;
  assign res_next.green = green_next;
  assign res_next.red   = red_next;
  assign res_next.gauge = gauge_next;
  assign res_next.reply = reply;

endmodule

`default_nettype wire

@@ src/hex_command_pwm_duty_setter.sv @@
`default_nettype none

// Hex command PWM duty setter. Each input word is either a received character
// (tuser low) or a timer tick (tuser high); every word gives exactly one output
// word with the four duties as they stand after it and a reply code. One word
// is taken every clock cycle while the output side is not stalled; an accepted
// word sits in the input register, the whole update of the duty state runs
// combinationally from it, and the result register captures the outcome.
// Back-pressure on the output side stalls both registers in place.

module hex_command_pwm_duty_setter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // char_code [7:0], demo_switch [8], zero [15:9]
  input  wire logic [hcpd_pkg::S_DATA_BITS-1:0] s_tdata,
  // operation [0]
  input  wire logic                             s_tuser,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // blue_duty [9:0], green_duty [19:10], red_duty [29:20], gauge_duty [39:30],
  // reply [41:40], zero [47:42]
  output      logic [hcpd_pkg::M_DATA_BITS-1:0] m_tdata
);

  logic                           in_valid;
  logic                           in_op;
  logic [hcpd_pkg::CHAR_BITS-1:0] in_char;
  logic                           in_demo;
  logic                           advance;
  logic                           step;
  hcpd_pkg::char_info_t           info;
  hcpd_pkg::result_t              res_next;
  hcpd_pkg::result_t              res;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_char <= s_tdata[hcpd_pkg::CHAR_BITS-1:0];
      in_demo <= s_tdata[hcpd_pkg::CHAR_BITS];
    end
  end

  hcpd_char_decode u_decode (
    .char_code (in_char),
    .info      (info)
  );

  hcpd_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .operation   (in_op),
    .demo_switch (in_demo),
    .info        (info),
    .res_next    (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign m_tdata = {6'd0, res.reply, res.gauge, res.red, res.green, res.blue};

endmodule

`default_nettype wire

@@ src/hcpd_checker.sv @@
`default_nettype none

module hcpd_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [hcpd_pkg::M_DATA_BITS-1:0] m_tdata
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // input side open after reset
  a_rst_in: assert property (@(posedge clk)
    $past(rst) |-> s_tready)
    else $error("input not ready after reset");

  // reply code is one of the defined ones and padding stays clear
  a_reply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[41:40] != 2'd3 && m_tdata[47:42] == 6'd0)
    else $error("bad reply code or padding");

endmodule

bind hex_command_pwm_duty_setter hcpd_checker u_hcpd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

module testbench;
  import hcpd_pkg::*;

  localparam int LIMIT = 3_000_000;
  localparam int RANDOM_WORDS = 1450;
  localparam int CALM_WORDS = 300;
  localparam int SWEEP_TICKS = 200;

  // character codes not in the package
  localparam logic [CHAR_BITS-1:0] CH_UP_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_NUL  = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_HIGH = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_BITS-1:0] s_tdata = '0;
  logic s_tuser = OP_CHAR;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_tdata;

  // duty state as the block should hold it
  logic [ACC_BITS-1:0]  hex_acc = '0;
  logic [DUTY_BITS-1:0] blue_lvl = COLOR_RESET;
  logic [DUTY_BITS-1:0] green_lvl = COLOR_RESET;
  logic [DUTY_BITS-1:0] red_lvl = COLOR_RESET;
  logic [DUTY_BITS-1:0] gauge_lvl = GAUGE_RESET;
  logic [CNT_BITS-1:0]  demo_cnt = '0;

  result_t pending_duties[$];
  int errors = 0;
  int live_words = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  hex_command_pwm_duty_setter DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [DUTY_BITS-1:0] clamp_duty(logic [ACC_BITS-1:0] a);
    return (a > DUTY_MAX) ? DUTY_MAX : a[DUTY_BITS-1:0];
  endfunction

  function automatic logic [CHAR_BITS-1:0] hex_char(logic [DIGIT_BITS-1:0] d);
    return (d < 4'd10) ? CH_0 + 8'(d) : CH_LO_A + 8'(d) - 8'd10;
  endfunction

  // advance the duty state by one word and return the output word it gives
  function automatic result_t predict_duties(logic op, logic [CHAR_BITS-1:0] ch, logic sw);
    result_t r;
    logic [2:0] flash;
    r.reply = REPLY_NONE;
    if (sw && op == OP_CHAR) begin
      if (ch >= CH_0 && ch <= CH_9) begin
        hex_acc = {hex_acc[ACC_BITS-DIGIT_BITS-1:0], ch[DIGIT_BITS-1:0]};
      end else if (ch >= CH_LO_A && ch <= CH_LO_F) begin
        hex_acc = {hex_acc[ACC_BITS-DIGIT_BITS-1:0], ch[DIGIT_BITS-1:0] + HEX_LETTER_OFS};
      end else if (ch != CH_LF) begin
        case (ch)
          CH_BANG: begin
            blue_lvl = DUTY_ZERO; green_lvl = DUTY_ZERO;
            red_lvl = DUTY_ZERO; gauge_lvl = DUTY_ZERO;
          end
          CH_AT: begin
            blue_lvl = DUTY_MAX; green_lvl = DUTY_MAX;
            red_lvl = DUTY_MAX; gauge_lvl = DUTY_MAX;
          end
          CH_UP_B: blue_lvl = DUTY_MAX - clamp_duty(hex_acc);
          CH_UP_G: green_lvl = DUTY_MAX - clamp_duty(hex_acc);
          CH_UP_R: red_lvl = DUTY_MAX - clamp_duty(hex_acc);
          CH_CR: begin
            gauge_lvl = clamp_duty(hex_acc);
            r.reply = REPLY_ACK;
          end
          default: r.reply = REPLY_ERR;
        endcase
        hex_acc = '0;
      end
    end else if (!sw && op == OP_TICK) begin
      // colors only change while the flash bit is clear
      if (!demo_cnt[FLASH_SHIFT]) begin
        flash = demo_cnt[FLASH_SHIFT +: 3];
        blue_lvl = flash[2] ? DUTY_MAX : BLUE_BASE;
        green_lvl = flash[1] ? DUTY_MAX : GREEN_BASE;
        red_lvl = flash[0] ? DUTY_MAX : RED_BASE;
      end
      demo_cnt = (demo_cnt == '0) ? DEMO_RELOAD : demo_cnt - 1'b1;
      gauge_lvl = demo_cnt[GAUGE_LSB +: DUTY_BITS];
    end
    r.blue = blue_lvl;
    r.green = green_lvl;
    r.red = red_lvl;
    r.gauge = gauge_lvl;
    return r;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // output side stalls in random bursts
  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each output word with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.blue = m_tdata[9:0];
      got.green = m_tdata[19:10];
      got.red = m_tdata[29:20];
      got.gauge = m_tdata[39:30];
      got.reply = reply_t'(m_tdata[41:40]);
      if (pending_duties.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_duties.pop_front();
        compare_field("blue", want.blue, got.blue);
        compare_field("green", want.green, got.green);
        compare_field("red", want.red, got.red);
        compare_field("gauge", want.gauge, got.gauge);
        compare_field("reply", want.reply, got.reply);
        compare_field("pad", 0, m_tdata[M_DATA_BITS-1:42]);
      end
    end
  end

  // send one word, sometimes with a random gap in front of it
  task automatic send_word(input logic op, input logic [CHAR_BITS-1:0] ch, input logic sw);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(S_DATA_BITS-CHAR_BITS-1){1'b0}}, sw, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_duties.push_back(predict_duties(op, ch, sw));
    if ((sw && op == OP_CHAR) || (!sw && op == OP_TICK)) live_words++;
  endtask

  // hex digits of a value, most significant first, in command mode
  task automatic send_number(input logic [23:0] value, input int digits);
    int i;
    for (i = digits - 1; i >= 0; i--) send_word(OP_CHAR, hex_char(value[4*i +: 4]), 1'b1);
  endtask

  function automatic logic [CHAR_BITS-1:0] pick_command();
    case ($urandom_range(0, 5))
      0: return CH_UP_B;
      1: return CH_UP_G;
      2: return CH_UP_R;
      3: return CH_CR;
      4: return CH_BANG;
      default: return CH_AT;
    endcase
  endfunction

  // ticks in command mode and characters in demo mode change nothing
  task automatic test_idle_modes();
    send_word(OP_TICK, CH_HIGH, 1'b1);
    send_word(OP_CHAR, CH_BANG, 1'b0);
  endtask

  task automatic test_commands();
    // every digit extreme, accumulator above the duty range
    send_number(24'h09af, 4);
    send_word(OP_CHAR, CH_UP_B, 1'b1);
    send_number(24'h3ff, 3);
    send_word(OP_CHAR, CH_UP_G, 1'b1);
    send_word(OP_CHAR, CH_UP_R, 1'b1);
    // line feed keeps the accumulator
    send_number(24'h12, 2);
    send_word(OP_CHAR, CH_LF, 1'b1);
    send_number(24'h3, 1);
    send_word(OP_CHAR, CH_CR, 1'b1);
    send_word(OP_CHAR, CH_BANG, 1'b1);
    send_word(OP_CHAR, CH_AT, 1'b1);
    // upper-case hex and odd codes are errors
    send_word(OP_CHAR, CH_UP_A, 1'b1);
    send_word(OP_CHAR, CH_HIGH, 1'b1);
    send_word(OP_CHAR, CH_NUL, 1'b1);
    send_number(24'h400, 3);
    send_word(OP_CHAR, CH_CR, 1'b1);
  endtask

  // steady tick run through the counter reload and the start of the countdown
  task automatic test_demo_sweep();
    quiet = 1'b1;
    repeat (SWEEP_TICKS) send_word(OP_TICK, CH_NUL, 1'b0);
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    int kind;
    int target;
    target = live_words + RANDOM_WORDS;
    while (live_words < target) begin
      if (live_words >= target - CALM_WORDS) quiet = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // well-formed command with random digits
        send_number(24'($urandom), $urandom_range(0, 5));
        if ($urandom_range(0, 7) == 0) send_word(OP_CHAR, CH_LF, 1'b1);
        send_word(OP_CHAR, pick_command(), 1'b1);
      end else if (kind == 6) begin
        repeat ($urandom_range(1, 40)) send_word(OP_TICK, 8'($urandom), 1'b0);
      end else if (kind == 7) begin
        send_word(1'($urandom), 8'($urandom), 1'($urandom));
      end else if (kind == 8) begin
        send_word(OP_CHAR, 8'($urandom), 1'b1);
      end else if ($urandom_range(0, 1) == 0) begin
        send_word(OP_CHAR, 8'($urandom), 1'b0);
      end else begin
        send_word(OP_TICK, 8'($urandom), 1'b1);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_idle_modes();
    test_commands();
    test_demo_sweep();
    test_random_traffic();
    s_tvalid <= 1'b0;
    quiet = 1'b1;
    while (pending_duties.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
src/hcpd_pkg.sv
src/hcpd_char_decode.sv
src/hcpd_engine.sv
src/hex_command_pwm_duty_setter.sv
src/hcpd_checker.sv
tb/testbench.sv
